[rtl/urtf_pkg.sv]
// Package for the unary resource timetable filter: widths, depths, status codes.
// No dependencies.
package urtf_pkg;
   localparam int MaxTasks = 32;
   localparam int TaskIdxW = $clog2(MaxTasks);
   localparam int CountW = TaskIdxW + 1;
   localparam int Horizon = 1024;
   localparam int ProfLen = Horizon + 2048;
   localparam int ProfAddrW = $clog2(ProfLen);
   localparam int TimeW = 10;
   localparam int LenW = 11;
   localparam int ReachW = 13;
   localparam int LoadW = 6;

   typedef enum logic [1:0] {
      STATUS_SAME     = 2'd0,
      STATUS_TIGHT    = 2'd1,
      STATUS_CONFLICT = 2'd2
   } status_type;
endpackage

[rtl/urtf_if.sv]
// Valid/ready channel interfaces for the timetable filter.
// Depends on urtf_pkg.
interface urtf_req_if;
   logic valid;
   logic ready;
   logic [urtf_pkg::TimeW-1:0] start_lo;
   logic [urtf_pkg::TimeW-1:0] start_hi;
   logic [urtf_pkg::LenW-1:0] len_lo;
   logic [urtf_pkg::LenW-1:0] len_hi;
   logic last_task;
   modport source (output valid, start_lo, start_hi, len_lo, len_hi, last_task, input ready);
   modport sink (input valid, start_lo, start_hi, len_lo, len_hi, last_task, output ready);
endinterface

interface urtf_rsp_if;
   logic valid;
   logic ready;
   logic [urtf_pkg::TaskIdxW-1:0] task_index;
   logic [urtf_pkg::TimeW-1:0] new_start_lo;
   logic [urtf_pkg::TimeW-1:0] new_start_hi;
   logic [1:0] status;
   logic last_result;
   modport source (output valid, task_index, new_start_lo, new_start_hi, status, last_result,
                   input ready);
   modport sink (input valid, task_index, new_start_lo, new_start_hi, status, last_result,
                 output ready);
endinterface

interface urtf_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[rtl/unary_resource_timetable_filter.sv]
// Unary resource timetable filter top level: task memory, load profile memory, sequencer.
// Depends on urtf_pkg and urtf_if.
// Operation: loading accepts one task per cycle while in the load state. A run clears the
// 3072-slot profile, checks each task, adds each mandatory part slot by slot, scans the
// profile slot by slot, then tests each candidate start slot by slot; results leave one at
// a time and wait while the receiver is not ready.
// Reset: synchronous, active high; clears control, task count, strict_mode to 1.
module unary_resource_timetable_filter (
   input logic clock,
   input logic reset,
   urtf_req_if.sink req,
   urtf_rsp_if.source rsp,
   urtf_csr_if.sink csr
);
   localparam int TW = urtf_pkg::TimeW;
   localparam int LW = urtf_pkg::LenW;
   localparam int RW = urtf_pkg::ReachW;
   localparam int AW = urtf_pkg::ProfAddrW;
   localparam int IW = urtf_pkg::TaskIdxW;
   localparam int CW = urtf_pkg::CountW;
   localparam int LDW = urtf_pkg::LoadW;
   localparam logic [RW-1:0] ProfLast = RW'(urtf_pkg::ProfLen - 1);
   localparam logic [TW-1:0] HzMax = TW'(urtf_pkg::Horizon - 1);

   typedef enum logic [12:0] {
      S_LOAD  = 13'h0001, S_CLEAR = 13'h0002, S_CHK   = 13'h0004,
      S_ADD   = 13'h0008, S_SCAN  = 13'h0010, S_TASK  = 13'h0020,
      S_FIT   = 13'h0040, S_NEXT  = 13'h0080, S_STRZ  = 13'h0100,
      S_STRK  = 13'h0200, S_EMIT  = 13'h0400, S_WAIT  = 13'h0800,
      S_CONF  = 13'h1000
   } state_type;

   // Task entry: original bounds and lengths; current bounds are kept in separate memories
   typedef struct packed {
      logic [TW-1:0] slo;
      logic [TW-1:0] shi;
      logic [LW-1:0] llo;
      logic [LW-1:0] lhi;
   } task_type;

   task_type task_mem [urtf_pkg::MaxTasks];
   logic [TW-1:0] cur_lo_mem [urtf_pkg::MaxTasks];
   logic [TW-1:0] cur_hi_mem [urtf_pkg::MaxTasks];
   logic [LDW-1:0] prof_mem [urtf_pkg::ProfLen];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;     // task walk index
   logic [CW-1:0] kdx_ff, kdx_in;     // inner task index
   logic [RW-1:0] t_ff, t_in;         // profile slot
   logic [RW-1:0] s_ff, s_in;         // candidate start
   logic [LW-1:0] off_ff, off_in;     // offset within candidate
   logic phase_ff, phase_in;          // 0 low search, 1 high search
   logic [TW-1:0] nlb_ff, nlb_in;
   logic strict_ff;
   logic rvalid_ff, rvalid_in;        // task read data valid
   task_type tk_ff;                   // registered task read
   logic [TW-1:0] clo_ff, chi_ff;
   logic [LDW-1:0] pr_ff;             // registered profile read
   logic [TW-1:0] zv_ff, zv_in;

   // Output register
   logic ov_ff, ov_in;
   logic [IW-1:0] oi_ff, oi_in;
   logic [TW-1:0] olo_ff, olo_in, ohi_ff, ohi_in;
   urtf_pkg::status_type ost_ff, ost_in;
   logic olast_ff, olast_in;

   // Memory ports
   logic [IW-1:0] traddr;
   logic twe;
   logic [IW-1:0] twaddr;
   task_type twdata;
   logic cwe;
   logic [IW-1:0] cwaddr;
   logic [TW-1:0] cwlo, cwhi;
   logic [AW-1:0] praddr, pwaddr;
   logic pwe;
   logic [LDW-1:0] pwdata;

   logic [TW-1:0] in_slo, in_shi;
   logic acc;
   logic [RW-1:0] lst, eet, slot;
   logic mand, seg_hit;

   assign in_slo = (req.start_lo > HzMax) ? HzMax : req.start_lo;
   assign in_shi = (req.start_hi > HzMax) ? HzMax : req.start_hi;
   assign req.ready = (state_ff == S_LOAD);
   assign acc = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign rsp.valid = ov_ff;
   assign rsp.task_index = oi_ff;
   assign rsp.new_start_lo = olo_ff;
   assign rsp.new_start_hi = ohi_ff;
   assign rsp.status = ost_ff;
   assign rsp.last_result = olast_ff;

   // Mandatory part of the registered task
   assign lst = RW'(tk_ff.shi);
   assign eet = RW'(tk_ff.slo) + RW'(tk_ff.llo);
   assign mand = lst < eet;
   assign slot = s_ff + RW'(off_ff);
   assign seg_hit = mand && (slot >= lst) && (slot < eet);

   // Memories
   always_ff @(posedge clock) begin
      if (twe) task_mem[twaddr] <= twdata;
      if (cwe) begin
         cur_lo_mem[cwaddr] <= cwlo;
         cur_hi_mem[cwaddr] <= cwhi;
      end
      tk_ff <= task_mem[traddr];
      clo_ff <= cur_lo_mem[traddr];
      chi_ff <= cur_hi_mem[traddr];
      if (pwe) prof_mem[pwaddr] <= pwdata;
      pr_ff <= prof_mem[praddr];
   end

   always_ff @(posedge clock) begin
      if (reset) strict_ff <= 1'b1;
      else if (csr.valid && csr.ready) strict_ff <= csr.data;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; kdx_in = kdx_ff;
      t_in = t_ff; s_in = s_ff; off_in = off_ff; phase_in = phase_ff; nlb_in = nlb_ff;
      rvalid_in = 1'b0; zv_in = zv_ff;
      ov_in = ov_ff; oi_in = oi_ff; olo_in = olo_ff; ohi_in = ohi_ff; ost_in = ost_ff;
      olast_in = olast_ff;
      traddr = idx_ff[IW-1:0];
      twe = 1'b0; twaddr = count_ff[IW-1:0];
      twdata = '{slo: in_slo, shi: in_shi, llo: req.len_lo, lhi: req.len_hi};
      cwe = 1'b0; cwaddr = idx_ff[IW-1:0]; cwlo = tk_ff.slo; cwhi = tk_ff.shi;
      praddr = t_ff[AW-1:0]; pwe = 1'b0; pwaddr = t_ff[AW-1:0]; pwdata = '0;
      if (rsp.ready) ov_in = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (acc) begin
               if (count_ff < CW'(urtf_pkg::MaxTasks)) begin
                  twe = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req.last_task) begin
                  state_in = S_CLEAR; t_in = '0;
               end
            end
         end
         S_CLEAR: begin
            pwe = 1'b1;
            t_in = t_ff + 1'b1;
            if (t_ff == ProfLast) begin
               state_in = S_CHK; idx_in = '0;
            end
         end
         // Domain check and copy of bounds, one task after another
         S_CHK: begin
            if (idx_ff == count_ff) begin
               state_in = S_ADD; idx_in = '0;
            end else if (!rvalid_ff) begin
               rvalid_in = 1'b1;
            end else if (tk_ff.slo > tk_ff.shi) begin
               state_in = S_CONF;
            end else begin
               cwe = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         // Add mandatory parts: read-modify-write one slot at a time
         S_ADD: begin
            if (idx_ff == count_ff) begin
               state_in = S_SCAN; t_in = '0; phase_in = 1'b0;
            end else if (!rvalid_ff) begin
               rvalid_in = 1'b1; kdx_in = '0; phase_in = 1'b0;
            end else if (kdx_ff[0] == 1'b0) begin
               // task entry now valid: walk from its latest start
               rvalid_in = 1'b1; kdx_in = CW'(1); t_in = lst;
            end else if (tk_ff.llo == '0 || t_ff >= eet || t_ff > ProfLast) begin
               idx_in = idx_ff + 1'b1; kdx_in = '0;
            end else if (!phase_ff) begin
               rvalid_in = 1'b1; phase_in = 1'b1;  // read issued at t_ff
            end else begin
               rvalid_in = 1'b1;
               pwe = 1'b1;
               pwdata = (pr_ff == '1) ? pr_ff : pr_ff + 1'b1;
               t_in = t_ff + 1'b1; phase_in = 1'b0;
            end
         end
         // Scan for overlap
         S_SCAN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (pr_ff > LDW'(1)) state_in = S_CONF;
               else if (t_ff == ProfLast) begin
                  state_in = S_TASK; idx_in = '0;
               end else t_in = t_ff + 1'b1;
            end
         end
         // Fetch task and current bounds
         S_TASK: begin
            if (idx_ff == count_ff) begin
               state_in = S_STRZ; idx_in = '0;
            end else if (!rvalid_ff) begin
               rvalid_in = 1'b1;
            end else if (tk_ff.llo == '0 || clo_ff == chi_ff) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = S_FIT; phase_in = 1'b0; kdx_in = '0;
               s_in = RW'(clo_ff); off_in = '0;
            end
         end
         // Test the candidate one slot at a time, low search then high search
         S_FIT: begin
            if (kdx_ff[0] == 1'b0) begin
               kdx_in = CW'(1);
               t_in = slot;
               praddr = slot[AW-1:0];
            end else begin
               logic bad, done, fit;
               logic [LDW-1:0] ld;
               kdx_in = '0;
               ld = (seg_hit && pr_ff != '0) ? pr_ff - 1'b1 : pr_ff;
               bad = (t_ff > ProfLast) || (ld != '0);
               done = (off_ff + 1'b1 >= tk_ff.llo);
               fit = !bad && done;
               if (!bad && !done) begin
                  off_in = off_ff + 1'b1;
               end else begin
                  off_in = '0;
                  if (!phase_ff) begin
                     if (fit) begin
                        nlb_in = s_ff[TW-1:0]; phase_in = 1'b1; s_in = RW'(chi_ff);
                     end else if (s_ff >= RW'(chi_ff)) state_in = S_CONF;
                     else s_in = s_ff + 1'b1;
                  end else begin
                     if (fit) begin
                        cwe = 1'b1; cwlo = nlb_ff; cwhi = s_ff[TW-1:0];
                        state_in = S_NEXT;
                     end else s_in = s_ff - 1'b1;  // a fit exists at nlb
                  end
               end
            end
         end
         S_NEXT: begin
            idx_in = idx_ff + 1'b1; state_in = S_TASK;
         end
         // Strict check: outer zero-length task
         S_STRZ: begin
            if (!strict_ff || idx_ff == count_ff) begin
               state_in = S_EMIT; idx_in = '0;
            end else if (!rvalid_ff) begin
               rvalid_in = 1'b1;
            end else if (tk_ff.lhi != '0 || clo_ff != chi_ff) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               zv_in = clo_ff; kdx_in = '0; state_in = S_STRK;
            end
         end
         S_STRK: begin
            traddr = kdx_ff[IW-1:0];
            if (kdx_ff == count_ff) begin
               idx_in = idx_ff + 1'b1; state_in = S_STRZ;
            end else if (!rvalid_ff) begin
               rvalid_in = 1'b1;
            end else begin
               kdx_in = kdx_ff + 1'b1;
               if (kdx_ff != idx_ff && tk_ff.llo == tk_ff.lhi && tk_ff.llo != '0
                   && clo_ff == chi_ff && clo_ff < zv_ff
                   && RW'(zv_ff) < RW'(clo_ff) + RW'(tk_ff.llo)) state_in = S_CONF;
            end
         end
         S_EMIT: begin
            if (!rvalid_ff) begin
               rvalid_in = 1'b1;
            end else if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1; oi_in = idx_ff[IW-1:0]; olo_in = clo_ff; ohi_in = chi_ff;
               ost_in = (clo_ff != tk_ff.slo || chi_ff != tk_ff.shi) ?
                        urtf_pkg::STATUS_TIGHT : urtf_pkg::STATUS_SAME;
               olast_in = (idx_ff + 1'b1 == count_ff);
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == count_ff) state_in = S_WAIT;
            end else rvalid_in = 1'b1;
         end
         S_CONF: begin
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1; oi_in = '0; olo_in = '0; ohi_in = '0;
               ost_in = urtf_pkg::STATUS_CONFLICT; olast_in = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            count_in = '0; idx_in = '0; kdx_in = '0; phase_in = 1'b0;
            state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
      // Empty set after last_task: nothing emitted
      if (state_ff == S_EMIT && count_ff == '0) begin
         state_in = S_WAIT; ov_in = ov_ff && !rsp.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; count_ff <= '0; idx_ff <= '0; kdx_ff <= '0;
         phase_ff <= 1'b0; rvalid_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; idx_ff <= idx_in; kdx_ff <= kdx_in;
         phase_ff <= phase_in; rvalid_ff <= rvalid_in; ov_ff <= ov_in;
      end
      t_ff <= t_in; s_ff <= s_in; off_ff <= off_in; nlb_ff <= nlb_in; zv_ff <= zv_in;
      oi_ff <= oi_in; olo_ff <= olo_in; ohi_ff <= ohi_in; ost_ff <= ost_in;
      olast_ff <= olast_in;
   end

   // Checks
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(urtf_pkg::MaxTasks)) else $error("task count overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !rsp.ready |=> ov_ff && $stable(olo_ff)) else $error("result lost");
   a_load_only: assert property (@(posedge clock) disable iff (reset)
      twe |-> state_ff == S_LOAD) else $error("task write outside load");
   a_conf_last: assert property (@(posedge clock) disable iff (reset)
      ov_ff && ost_ff == urtf_pkg::STATUS_CONFLICT |-> olast_ff) else $error("conflict not last");
endmodule
